>>> design/stdf_pkg.sv
// Shared types and constants for the seven-tap derivative FIR.
package stdf_pkg;

    // Filter geometry and field widths
    localparam int TAPS         = 7;
    localparam int COEF_BITS    = 8;
    localparam int OUT_BITS     = 15;
    localparam int CFG_IDX_BITS = 4;
    localparam int CFG_DAT_BITS = 8;

    // Flush and warm-up counters
    localparam logic [1:0] FLUSH_STEPS = 2'd3;
    localparam logic [1:0] FLUSH_FINAL = 2'd1;
    localparam logic [1:0] WARM_FULL   = 2'd3;

    // Register map
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORDER_SEL = 4'd7;

    typedef logic signed [COEF_BITS-1:0] t_coef;

    localparam t_coef COEF_RESET [TAPS] = '{
        8'sd0, -8'sd1, 8'sd8, 8'sd0, -8'sd8, 8'sd1, 8'sd0
    };
    localparam logic ORDER_SEL_RESET = 1'b1;

    // Per-step control broadcast to every tap cell
    typedef struct packed {
        logic shift;   // a step moves the delay line this cycle
        logic clear;   // final flush step: line clears after the step
    } t_cell_ctl;

endpackage

>>> design/seven_tap_derivative_fir.sv
// Seven-tap derivative FIR: step sequencer, tap cell chain, adder and scaler.
// An accepted sample passes through the tap product, sum and output registers.
// Throughput: one sample per cycle unless stalled; a sample marked last adds flush
// steps, with o_in_ready low, while the flush counter drives zeros into the chain.
// Backpressure from i_out_ready stalls the chain only once all stages hold beats.
// Reset (synchronous, active low) clears delay line, counters, valids; loads config regs.
module seven_tap_derivative_fir
    import stdf_pkg::*;
#(
    parameter int SAMPLE_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last_sample,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [OUT_BITS-1:0]    o_filtered,
    output logic                          o_last_result,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [CFG_DAT_BITS-1:0]       i_cfg_data
);

    localparam int PW = SAMPLE_BITS + COEF_BITS;
    localparam int SW = PW + 3;
    localparam int QW = SW + 1;
    localparam logic signed [QW-1:0] Q_HI = QW'(2 ** (OUT_BITS - 1) - 1);
    localparam logic signed [QW-1:0] Q_LO = -Q_HI - QW'(1);

    // Configuration registers
    t_coef r_coef [TAPS];
    logic  r_order;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_coef[i] <= COEF_RESET[i];
            end
            r_order <= ORDER_SEL_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index < CFG_IDX_BITS'(TAPS)) begin
                r_coef[i_cfg_index[2:0]] <= t_coef'(i_cfg_data);
            end else if (i_cfg_index == CFG_ORDER_SEL) begin
                r_order <= i_cfg_data[0];
            end
        end
    end

    // Pipeline flow control
    logic r_pv, r_plast;
    logic r_sv, r_slast;
    logic r_ov, r_olast;
    logic out_free, sum_free, prod_free;

    assign out_free  = !r_ov || i_out_ready;
    assign sum_free  = !r_sv || out_free;
    assign prod_free = !r_pv || sum_free;

    // Step sequencer: samples, then flush steps after a last sample
    logic [1:0] r_flush, n_flush;
    logic [1:0] r_warm, n_warm;
    logic       flushing, step_en, final_step, result_due;
    logic signed [SAMPLE_BITS-1:0] step_data;
    t_cell_ctl  cell_ctl;

    assign flushing   = (r_flush != 2'd0);
    assign o_in_ready = prod_free && !flushing;
    assign step_en    = prod_free && (flushing || i_in_valid);
    assign final_step = (r_flush == FLUSH_FINAL);
    assign result_due = (r_warm == WARM_FULL);
    assign step_data  = flushing ? '0 : i_sample;

    assign cell_ctl.shift = step_en;
    assign cell_ctl.clear = final_step;

    always_comb begin
        n_flush = r_flush;
        n_warm  = r_warm;
        if (step_en) begin
            if (flushing) begin
                n_flush = r_flush - 2'd1;
            end else if (i_last_sample) begin
                n_flush = FLUSH_STEPS;
            end
            if (final_step) begin
                n_warm = 2'd0;
            end else if (!result_due) begin
                n_warm = r_warm + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush <= 2'd0;
            r_warm  <= 2'd0;
        end else begin
            r_flush <= n_flush;
            r_warm  <= n_warm;
        end
    end

    // Tap cell chain, newest sample at cell 0
    logic signed [SAMPLE_BITS-1:0] d_in   [TAPS];
    logic signed [SAMPLE_BITS-1:0] d_out  [TAPS];
    logic signed [PW-1:0]          prod   [TAPS];

    assign d_in[0] = step_data;

    for (genvar g = 0; g < TAPS; g++) begin : g_tap
        if (g > 0) begin : g_link
            assign d_in[g] = d_out[g-1];
        end
        stdf_tap_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (cell_ctl),
            .i_d    (d_in[g]),
            .i_coef (r_coef[TAPS-1-g]),
            .o_d    (d_out[g]),
            .o_prod (prod[g])
        );
    end

    // Product stage tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_plast <= 1'b0;
        end else if (prod_free) begin
            r_pv    <= step_en && result_due;
            r_plast <= step_en && final_step;
        end
    end

    // Sum stage
    logic signed [SW-1:0] r_sum, n_sum;

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < TAPS; i++) begin
            n_sum = n_sum + SW'(prod[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv    <= 1'b0;
            r_slast <= 1'b0;
        end else if (sum_free) begin
            r_sv    <= r_pv;
            r_slast <= r_plast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_free) begin
            r_sum <= n_sum;
        end
    end

    // Signed shift that rounds toward zero
    function automatic logic signed [QW-1:0] shr_tz(input logic signed [SW-1:0] v,
                                                   input int unsigned k);
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] bias;
        w    = QW'(v);
        bias = v[SW-1] ? ((QW'(1) <<< k) - QW'(1)) : '0;
        return (w + bias) >>> k;
    endfunction

    // Scale and saturate
    logic signed [QW-1:0]       q;
    logic signed [OUT_BITS-1:0] q_sat;

    always_comb begin
        q = shr_tz(r_sum, 6) + shr_tz(r_sum, 10);
        if (!r_order) begin
            q = q + shr_tz(r_sum, 4) + shr_tz(r_sum, 8);
        end
        if (q > Q_HI) begin
            q_sat = OUT_BITS'(Q_HI);
        end else if (q < Q_LO) begin
            q_sat = OUT_BITS'(Q_LO);
        end else begin
            q_sat = OUT_BITS'(q);
        end
    end

    // Output register
    logic signed [OUT_BITS-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_olast <= 1'b0;
        end else if (out_free) begin
            r_ov    <= r_sv;
            r_olast <= r_slast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_sv) begin
            r_out <= q_sat;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_filtered    = r_out;
    assign o_last_result = r_ov && r_olast;

`ifndef ASSERT_OFF
    // no sample is taken while flush steps remain
    a_no_accept_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flushing |-> !o_in_ready)
        else $error("sample accepted during flush");

    // a last sample arms the full flush sequence
    a_flush_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_sample) |=> (r_flush == FLUSH_STEPS))
        else $error("flush not armed after last sample");

    // the final flush step always carries a result and clears the window
    a_final_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_en && final_step) |-> result_due)
        else $error("final flush step without result");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_en && final_step) |=> (r_warm == 2'd0 && d_out[0] == '0
                                     && d_out[TAPS-1] == '0))
        else $error("window not cleared after flush");

    // a marked result never travels without a valid beat
    a_last_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_plast |-> r_pv) and (r_slast |-> r_sv))
        else $error("last mark on empty stage");
`endif

endmodule

>>> design/stdf_tap_cell.sv
// One tap of the delay line: holds a sample, passes it on, registers its product.
module stdf_tap_cell
    import stdf_pkg::*;
#(
    parameter int SAMPLE_BITS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  t_cell_ctl                               i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]           i_d,
    input  t_coef                                   i_coef,
    output logic signed [SAMPLE_BITS-1:0]           o_d,
    output logic signed [SAMPLE_BITS+COEF_BITS-1:0] o_prod
);

    localparam int PW = SAMPLE_BITS + COEF_BITS;

    logic signed [SAMPLE_BITS-1:0] r_d, n_d;
    logic signed [PW-1:0]          r_prod, n_prod;

    // Tap value: take the neighbor's sample on a step, zero on the final flush
    always_comb begin
        n_d = r_d;
        if (i_ctl.shift) begin
            n_d = i_ctl.clear ? '0 : i_d;
        end
    end

    // Product of the value that enters this tap on the step
    always_comb begin
        n_prod = r_prod;
        if (i_ctl.shift) begin
            n_prod = PW'(i_d) * PW'(i_coef);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else begin
            r_d <= n_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_d    = r_d;
    assign o_prod = r_prod;

endmodule

>>> bench/fir_result_checker.sv
// Checker for the seven-tap derivative FIR: tracks config, predicts results, compares beats.
`timescale 1ns / 1ps

module fir_result_checker
    import stdf_pkg::*;
#(
    parameter int SAMPLE_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last_sample,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [OUT_BITS-1:0]    i_filtered,
    input  logic                          i_last_result,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [CFG_DAT_BITS-1:0]       i_cfg_data,
    output int                            o_fail_count,
    output int                            o_due_count
);

    localparam int OUT_MAX = 2 ** (OUT_BITS - 1) - 1;
    localparam int OUT_MIN = -(2 ** (OUT_BITS - 1));

    typedef struct {
        logic signed [OUT_BITS-1:0] filtered;
        logic                       last_result;
    } t_fir_beat;

    // Shadow copy of the filter state and registers
    t_coef                         tap_coef [TAPS];
    logic                          order_sel;
    logic signed [SAMPLE_BITS-1:0] window [TAPS];
    int                            warm;

    t_fir_beat filtered_due [$];
    t_fir_beat head;
    int        fail_total = 0;

    // One shift of the delay line; queues a result once the window is warm
    function automatic void shift_and_filter(input logic signed [SAMPLE_BITS-1:0] smp);
        int        acc;
        int        q;
        t_fir_beat res;
        for (int i = TAPS - 1; i > 0; i--) window[i] = window[i - 1];
        window[0] = smp;
        acc = 0;
        for (int i = 0; i < TAPS; i++) acc += int'(window[i]) * int'(tap_coef[TAPS - 1 - i]);
        if (warm < int'(WARM_FULL)) begin
            warm++;
            return;
        end
        q = acc / 64 + acc / 1024;
        if (!order_sel) q += acc / 16 + acc / 256;
        if (q > OUT_MAX) q = OUT_MAX;
        if (q < OUT_MIN) q = OUT_MIN;
        res.filtered    = OUT_BITS'(q);
        res.last_result = 1'b0;
        filtered_due.push_back(res);
    endfunction

    // Full step for one accepted sample, flush included
    function automatic void predict_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                                           input logic last);
        int n_prior;
        n_prior = filtered_due.size();
        shift_and_filter(smp);
        if (!last) return;
        for (int f = 0; f < int'(FLUSH_STEPS); f++) shift_and_filter('0);
        if (filtered_due.size() > n_prior) filtered_due[$].last_result = 1'b1;
        for (int i = 0; i < TAPS; i++) window[i] = '0;
        warm = 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                tap_coef[i] = COEF_RESET[i];
                window[i]   = '0;
            end
            order_sel = ORDER_SEL_RESET;
            warm      = 0;
            filtered_due.delete();
        end else begin
            // register writes; indexes past the map are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index < TAPS)
                    tap_coef[i_cfg_index[2:0]] = t_coef'(i_cfg_data);
                else if (i_cfg_index == CFG_ORDER_SEL)
                    order_sel = i_cfg_data[0];
            end
            if (i_in_valid && i_in_ready) predict_sample(i_sample, i_last_sample);
            // result beat against oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (filtered_due.size() == 0) begin
                    $error("unexpected result beat: filtered %0d last_result %0d",
                           i_filtered, i_last_result);
                    fail_total++;
                end else begin
                    head = filtered_due.pop_front();
                    if (i_filtered !== head.filtered) begin
                        $error("filtered: expected %0d, got %0d", head.filtered, i_filtered);
                        fail_total++;
                    end
                    if (i_last_result !== head.last_result) begin
                        $error("last_result: expected %0d, got %0d",
                               head.last_result, i_last_result);
                        fail_total++;
                    end
                end
            end
        end
        o_due_count  <= filtered_due.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> bench/tb.sv
// Testbench top for the seven-tap derivative FIR: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb;
    import stdf_pkg::*;

    localparam int SAMPLE_BITS = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 8;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample      = '0;
    logic                          i_last_sample = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready   = 1'b0;
    logic signed [OUT_BITS-1:0]    o_filtered;
    logic                          o_last_result;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]       i_cfg_index   = '0;
    logic [CFG_DAT_BITS-1:0]       i_cfg_data    = '0;

    int fail_count;
    int due_count;
    int cycle_count = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;

    // register values for the next load
    logic [CFG_DAT_BITS-1:0] coef_set [TAPS];
    logic                    order_set;

    seven_tap_derivative_fir #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_filtered    (o_filtered),
        .o_last_result (o_last_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    fir_result_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_filtered    (o_filtered),
        .i_last_result (o_last_result),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_due_count   (due_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side stalls at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // one sample beat; valid stays high afterwards for back-to-back beats
    task automatic put_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_sample      <= s;
        i_last_sample <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // hold the sender until every expected result has come back
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [CFG_DAT_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // write every tap and the order select, plus a write to an unmapped index
    task automatic load_filter();
        for (int i = 0; i < TAPS; i++) cfg_beat(CFG_IDX_BITS'(i), coef_set[i]);
        cfg_beat(CFG_IDX_BITS'($urandom_range(2 ** CFG_IDX_BITS - 1, CFG_ORDER_SEL + 1)),
                 CFG_DAT_BITS'($urandom));
        cfg_beat(CFG_ORDER_SEL, CFG_DAT_BITS'(order_set));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_stream(input int len);
        logic signed [SAMPLE_BITS-1:0] s;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(7))
                0:       s = SMP_MAX;
                1:       s = SMP_MIN;
                2:       s = '0;
                3:       s = '1;
                default: s = SAMPLE_BITS'($urandom);
            endcase
            put_sample(s, k == len - 1);
        end
    endtask

    initial begin
        int sent;
        int len;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset coefficients, extremes and a full stream
        put_sample(SMP_MAX, 1'b0);
        put_sample(SMP_MIN, 1'b0);
        put_sample(SAMPLE_BITS'(0), 1'b0);
        put_sample(SAMPLE_BITS'(1), 1'b0);
        put_sample(SAMPLE_BITS'(-1), 1'b0);
        put_sample(SAMPLE_BITS'(64), 1'b0);
        put_sample(SAMPLE_BITS'(-64), 1'b1);
        // one-sample stream: all results come from the flush
        put_sample(SAMPLE_BITS'(5), 1'b1);
        wait_drain();

        // all taps at the negative extreme, order-3 scaling: largest positive sum
        foreach (coef_set[i]) coef_set[i] = 8'h80;
        order_set = 1'b0;
        load_filter();
        repeat (6) put_sample(SMP_MIN, 1'b0);
        put_sample(SMP_MIN, 1'b1);
        put_sample(SMP_MAX, 1'b0);
        put_sample(SMP_MIN, 1'b1);
        wait_drain();

        // all taps at the positive extreme, order-5 scaling
        foreach (coef_set[i]) coef_set[i] = 8'h7F;
        order_set = 1'b1;
        load_filter();
        put_sample(SMP_MIN, 1'b0);
        put_sample(SMP_MIN, 1'b0);
        put_sample(SMP_MAX, 1'b1);
        put_sample(SAMPLE_BITS'(0), 1'b1);
        wait_drain();

        // random streams over three pacing phases, two settings each
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin in_idle_pct = 21; out_idle_pct = 57; end
                1:       begin in_idle_pct = 57; out_idle_pct = 21; end
                default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                foreach (coef_set[i]) begin
                    case ($urandom_range(5))
                        0:       coef_set[i] = 8'h7F;
                        1:       coef_set[i] = 8'h80;
                        default: coef_set[i] = CFG_DAT_BITS'($urandom);
                    endcase
                end
                order_set = 1'($urandom_range(1));
                load_filter();
                sent = 0;
                while (sent < 21) begin
                    // mostly full windows, some short streams
                    if ($urandom_range(4) == 0) len = $urandom_range(1, 3);
                    else len = $urandom_range(4, 16);
                    random_stream(len);
                    sent += len;
                    // mid-run pause with the line empty of pending results
                    if (ph == 0 && sub == 0 && sent < 12) wait_drain();
                end
                wait_drain();
            end
        end

        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
